/* rtl/core/assert_macros.svh */
// assertion macros for the rtl files that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge outside of reset
`define CHECK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property that only needs to hold in the cycle after a trigger
`define CHECK_NEXT(label, trig, prop, msg) \
	`CHECK_CLK(label, (trig) |=> (prop), msg)

`endif

/* rtl/core/lrou_pkg.sv */
// package: constants, function codes and controller/datapath link types for the looper
package lrou_pkg;

	localparam int LOOP_LENGTH  = 262144;
	localparam int SAMPLE_WIDTH = 24;
	localparam int POS_W        = 18;
	localparam int TAKE_W       = 8;
	localparam int ADDR_W       = $clog2(LOOP_LENGTH);

	typedef enum logic [1:0] {
		FN_SAMPLE = 2'd0,
		FN_TAKE   = 2'd1,
		FN_UNDO   = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [TAKE_W-1:0]              take_t;
	typedef logic [ADDR_W-1:0]              addr_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
		logic clear_step;
	} lrou_cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  clear_last;
	} lrou_sts_t;

endpackage

/* rtl/core/lrou_in_if.sv */
// request channel interface: function code, loop position and input sample
interface lrou_in_if
	import lrou_pkg::*;
;
	logic                     valid;
	logic                     ready;
	func_t                    func;
	logic [POS_W-1:0]         position;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output func, output position, output sample_in, input ready);
	modport sink (input valid, input func, input position, input sample_in, output ready);
endinterface

/* rtl/core/lrou_out_if.sv */
// result channel interface: played sample, take counter and empty flag
interface lrou_out_if
	import lrou_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [SAMPLE_WIDTH-1:0] play_sample;
	logic [TAKE_W-1:0]        take_count;
	logic                     is_empty;

	modport source (output valid, output play_sample, output take_count, output is_empty,
		input ready);
	modport sink (input valid, input play_sample, input take_count, input is_empty,
		output ready);
endinterface

/* rtl/core/lrou_ram.sv */
// generic single write port, single read port ram with registered read data
module lrou_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* rtl/core/lrou_dp.sv */
// datapath: loop bank memories, overdub adder with saturation, take counters, result register
module lrou_dp
	import lrou_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lrou_cmd_t           cmd,
	output lrou_sts_t           sts,
	input  func_t               func,
	input  logic [POS_W-1:0]    position,
	input  sample_t             sample_in,
	output sample_t             play_sample,
	output take_t               take_count,
	output logic                is_empty
);
	func_t   func_q;
	addr_t   pos_q;
	sample_t smp_q;
	addr_t   clr_addr_q;

	take_t take_q, prev_q, cur_q;
	logic  play_bank_q, rec_bank_q;

	take_t take_d, prev_d, cur_d;

	sample_t play_sample_q;
	take_t   take_count_q;
	logic    is_empty_q;

	addr_t   rd_addr;
	sample_t rdata [2];
	sample_t played;
	logic signed [SAMPLE_WIDTH:0] sum;
	sample_t mixed;
	sample_t wr_val;
	logic    smp_commit;

	localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	assign rd_addr = ADDR_W'(position);

	// item capture and clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q     <= FN_SAMPLE;
			clr_addr_q <= '0;
		end else begin
			if (cmd.capture) begin
				func_q <= func;
			end
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + addr_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= rd_addr;
			smp_q <= sample_in;
		end
	end

	assign sts.func       = func_q;
	assign sts.clear_last = (clr_addr_q == '1);

	// play bank sample, valid from the cycle after capture
	assign played = play_bank_q ? rdata[1] : rdata[0];

	// overdub mix with saturation
	assign sum = {played[SAMPLE_WIDTH-1], played} + {smp_q[SAMPLE_WIDTH-1], smp_q};
	always_comb begin
		if (sum[SAMPLE_WIDTH] != sum[SAMPLE_WIDTH-1]) begin
			mixed = sum[SAMPLE_WIDTH] ? SMP_MIN : SMP_MAX;
		end else begin
			mixed = sum[SAMPLE_WIDTH-1:0];
		end
	end

	// first take records the dry input
	assign wr_val     = (take_q == '0) ? smp_q : mixed;
	assign smp_commit = cmd.commit && (func_q == FN_SAMPLE);

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic    we;
		addr_t   waddr;
		sample_t wdata;

		assign we    = cmd.clear_step || (smp_commit && (rec_bank_q == 1'(b)));
		assign waddr = cmd.clear_step ? clr_addr_q : pos_q;
		assign wdata = cmd.clear_step ? '0 : wr_val;

		lrou_ram #(
			.WIDTH (SAMPLE_WIDTH),
			.DEPTH (LOOP_LENGTH)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (cmd.capture),
			.raddr (rd_addr),
			.rdata (rdata[b])
		);
	end

	// take counter update for the committed item
	always_comb begin
		take_d = take_q;
		prev_d = prev_q;
		cur_d  = cur_q;
		unique case (func_q)
			FN_SAMPLE: begin
			end
			FN_TAKE: begin
				prev_d = take_q;
				take_d = take_q + take_t'(1);
				cur_d  = take_q + take_t'(1);
			end
			FN_UNDO: begin
				take_d = prev_q;
				prev_d = cur_q;
				cur_d  = prev_q;
			end
			FN_CLEAR: begin
				take_d = '0;
				prev_d = '0;
				cur_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_q      <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			play_bank_q <= 1'b0;
			rec_bank_q  <= 1'b0;
		end else if (cmd.commit) begin
			take_q      <= take_d;
			prev_q      <= prev_d;
			cur_q       <= cur_d;
			play_bank_q <= prev_d[0];
			rec_bank_q  <= cur_d[0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			play_sample_q <= (func_q == FN_SAMPLE) ? played : '0;
			take_count_q  <= take_d;
			is_empty_q    <= (take_d == '0);
		end
	end

	assign play_sample = play_sample_q;
	assign take_count  = take_count_q;
	assign is_empty    = is_empty_q;
endmodule

/* rtl/core/lrou_ctrl.sv */
// controller: request sequencing, result valid and bank clear sweep
module lrou_ctrl
	import lrou_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output lrou_cmd_t cmd,
	input  lrou_sts_t sts,
	output logic      clearing
);
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free      = !out_valid_q || rsp_ready;
	assign cmd.capture    = (state_q == ST_IDLE) && req_valid;
	assign cmd.commit     = (state_q == ST_DONE) && slot_free;
	assign cmd.clear_step = (state_q == ST_CLEAR);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign clearing  = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// a clear request sweeps both banks before the next request
					if (slot_free) begin
						state_q <= (sts.func == FN_CLEAR) ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end
endmodule

/* rtl/core/loop_record_overdub_undo.sv */
// top level: audio looper with two ping-pong loop banks and overdub undo
// Each request is accepted in the idle state, where the play-bank read is issued, and its
// result is committed from the done state, together with the record-bank write, once the result
// register is free; a result waiting on the output does not block acceptance beyond that.
// Sample requests return the play-bank sample at their position (read before the write);
// add-take, undo and clear return zero with the updated take count. After reset and after
// every clear request, the controller sweeps both loop banks to zero, one address per cycle
// for both banks at once; no request is accepted during that sweep.
`include "assert_macros.svh"

module loop_record_overdub_undo
	import lrou_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	lrou_in_if.sink    req,
	lrou_out_if.source rsp
);
	lrou_cmd_t cmd;
	lrou_sts_t sts;
	logic      clearing;

	lrou_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts),
		.clearing  (clearing)
	);

	lrou_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (req.func),
		.position    (req.position),
		.sample_in   (req.sample_in),
		.play_sample (rsp.play_sample),
		.take_count  (rsp.take_count),
		.is_empty    (rsp.is_empty)
	);

	`CHECK_CLK(a_no_req_in_sweep, clearing |-> !req.ready, "request accepted during clear sweep")
	`CHECK_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "request overlap")
	`CHECK_CLK(a_empty_flag, rsp.valid |-> (rsp.is_empty == (rsp.take_count == '0)), "is_empty mismatch")
	`CHECK_NEXT(a_commit_valid, cmd.commit, rsp.valid, "committed result not presented")
endmodule
